// ===== hdl/clu_pkg.sv =====
// Package for the lexicographic combination unranking block.
// Holds field widths, register indexes and the controller state type.
// No dependencies.
`timescale 1ns / 1ps

package clu_pkg;

  localparam int RankW   = 30;  // rank input field
  localparam int ElemW   = 6;   // element output field, also n and i
  localparam int CoefW   = 30;  // binomial coefficient width
  localparam int CfgIdxW = 2;   // configuration register index

  localparam logic [CfgIdxW-1:0] CFG_SET_SIZE    = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_SUBSET_SIZE = 2'd1;

  localparam logic [ElemW-1:0] SET_SIZE_RST    = 6'd32;
  localparam logic [ElemW-1:0] SUBSET_SIZE_RST = 6'd1;

  typedef enum logic [4:0] {
    S_FILL  = 5'b00001,  // build the binomial table after reset
    S_IDLE  = 5'b00010,  // wait for a rank
    S_CHECK = 5'b00100,  // compare rank against C(n,i)
    S_EVAL  = 5'b01000,  // walk candidates, one table read each
    S_LAST  = 5'b10000   // emit the final element
  } state_t;

endpackage

// ===== hdl/clu_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Read data holds while the read enable is low. No dependencies.
`timescale 1ns / 1ps

module clu_ram #(
  parameter int WIDTH  = 30,
  parameter int DEPTH  = 1089,
  parameter int ADDR_W = $clog2(DEPTH)
) (
  input  logic              clk,
  input  logic              wr_en,
  input  logic [ADDR_W-1:0] wr_addr,
  input  logic [WIDTH-1:0]  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output logic [WIDTH-1:0]  rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ===== hdl/combination_unrank_lex.sv =====
// Top level of the lexicographic combination unranking block.
// Depends on clu_pkg (widths, register indexes, state type) and clu_ram.
`timescale 1ns / 1ps

// Channel  Dir  Handshake           Payload
// in_      in   in_tvalid/tready    tdata[29:0] rank
// out_     out  out_tvalid/tready   tdata[5:0] element, tlast last, tuser rank_error
// cfg_     in   cfg_we              cfg_index register, cfg_wdata value
//
// Walk: each candidate element costs one read of the binomial table RAM, and
// the next rank is taken only after the last result of a rank is registered.
// Reset: the binomial table is built by Pascal's rule, one entry a cycle;
// no rank is taken until the last entry is written, configuration writes
// are taken throughout.
// Stalls: a full output register holds the walk once it has an element to emit;
// the next rank is taken as soon as the final result sits in the output register.

module combination_unrank_lex
  import clu_pkg::*;
#(
  parameter int MAX_N = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  // input stream
  input  logic               in_tvalid,
  output logic               in_tready,
  input  logic [31:0]        in_tdata,   // [29:0] rank, [31:30] zero
  // result stream
  output logic               out_tvalid,
  input  logic               out_tready,
  output logic [7:0]         out_tdata,  // [5:0] element, [7:6] zero
  output logic               out_tlast,  // last
  output logic               out_tuser,  // rank_error
  // configuration
  input  logic               cfg_we,
  input  logic [CfgIdxW-1:0] cfg_index,
  input  logic [ElemW-1:0]   cfg_wdata
);

  localparam int Dim   = MAX_N + 1;
  localparam int Depth = Dim * Dim;
  localparam int AddrW = $clog2(Depth);
  localparam int Last  = Depth - 1;

  // table address of C(a,b)
  function automatic logic [AddrW-1:0] addr_of(input logic [ElemW-1:0] a,
                                               input logic [ElemW-1:0] b);
    addr_of = AddrW'(32'(a) * Dim + 32'(b));
  endfunction

  // ------------------------------------------------------------------
  // Registers
  // ------------------------------------------------------------------
  state_t             state_r, state_nxt;
  logic [ElemW-1:0]   set_size_r, subset_size_r;

  logic [RankW-1:0]   rank_r, rank_nxt;
  logic [ElemW-1:0]   cand_r, cand_nxt;
  logic [ElemW-1:0]   prev_r, prev_nxt;
  logic [CoefW-1:0]   sum_r, sum_nxt;
  logic [ElemW-1:0]   bsel_r, bsel_nxt;       // i - position - 1
  logic               coef_zero_r, coef_zero_nxt;

  // table build pipeline
  logic [AddrW-1:0]   fill_addr_r, fill_addr_nxt;
  logic [ElemW-1:0]   fill_row_r, fill_row_nxt;
  logic [ElemW-1:0]   fill_col_r, fill_col_nxt;
  logic               wr_en_r, wr_en_nxt;
  logic [AddrW-1:0]   wr_addr_r, wr_addr_nxt;
  logic               wr_row0_r, wr_row0_nxt;
  logic               wr_col0_r, wr_col0_nxt;
  logic [CoefW-1:0]   prev_rd_r;

  // output register
  logic               out_valid_r, out_valid_nxt;
  logic [ElemW-1:0]   out_elem_r, out_elem_nxt;
  logic               out_last_r, out_last_nxt;
  logic               out_err_r, out_err_nxt;

  // ------------------------------------------------------------------
  // Table RAM
  // ------------------------------------------------------------------
  logic               rd_en;
  logic [AddrW-1:0]   rd_addr;
  logic [CoefW-1:0]   rd_data;
  logic [CoefW-1:0]   wr_data;

  clu_ram #(
    .WIDTH  (CoefW),
    .DEPTH  (Depth),
    .ADDR_W (AddrW)
  ) u_rom (
    .clk     (clk),
    .wr_en   (wr_en_r),
    .wr_addr (wr_addr_r),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  // Pascal's rule: C(a,b) = C(a-1,b) + C(a-1,b-1); row zero is 1 then zeros.
  always_comb begin
    if (wr_row0_r) begin
      wr_data = wr_col0_r ? CoefW'(1) : '0;
    end else if (wr_col0_r) begin
      wr_data = rd_data;
    end else begin
      wr_data = rd_data + prev_rd_r;
    end
  end

  // ------------------------------------------------------------------
  // Handshake and shared decode
  // ------------------------------------------------------------------
  logic               in_accept;
  logic               out_free;
  logic               size_bad;
  logic [CoefW:0]     sum_ext;
  logic               keep_going;
  logic [CoefW-1:0]   coef;
  logic [ElemW-1:0]   next_a;
  logic [ElemW-1:0]   bsel_dec;

  // hold off while the last table entry is still being written
  assign in_tready = (state_r == S_IDLE) && !wr_en_r;
  assign in_accept = in_tvalid && in_tready;
  assign out_free  = !out_valid_r || out_tready;

  assign size_bad = (set_size_r == '0) || (32'(set_size_r) > MAX_N) ||
                    (subset_size_r == '0) || (subset_size_r > set_size_r);

  assign coef       = coef_zero_r ? '0 : rd_data;
  assign sum_ext    = {1'b0, sum_r} + {1'b0, coef};
  assign keep_going = (sum_ext < {1'b0, rank_r}) && (cand_r < set_size_r);
  assign next_a     = set_size_r - cand_r - ElemW'(1);
  assign bsel_dec   = bsel_r - ElemW'(1);

  // ------------------------------------------------------------------
  // Controller
  // ------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    rank_nxt      = rank_r;
    cand_nxt      = cand_r;
    prev_nxt      = prev_r;
    sum_nxt       = sum_r;
    bsel_nxt      = bsel_r;
    coef_zero_nxt = coef_zero_r;

    fill_addr_nxt = fill_addr_r;
    fill_row_nxt  = fill_row_r;
    fill_col_nxt  = fill_col_r;
    wr_en_nxt     = 1'b0;
    wr_addr_nxt   = fill_addr_r;
    wr_row0_nxt   = (fill_row_r == '0);
    wr_col0_nxt   = (fill_col_r == '0);

    out_valid_nxt = out_valid_r && !out_tready;
    out_elem_nxt  = out_elem_r;
    out_last_nxt  = out_last_r;
    out_err_nxt   = out_err_r;

    rd_en   = 1'b0;
    rd_addr = addr_of(set_size_r, subset_size_r);

    unique case (state_r)
      S_FILL: begin
        // issue one table entry a cycle, write it the cycle after
        wr_en_nxt = 1'b1;
        rd_en     = (fill_row_r != '0);
        rd_addr   = fill_addr_r - AddrW'(Dim);
        fill_addr_nxt = fill_addr_r + AddrW'(1);
        if (32'(fill_col_r) == MAX_N) begin
          fill_col_nxt = '0;
          fill_row_nxt = fill_row_r + ElemW'(1);
        end else begin
          fill_col_nxt = fill_col_r + ElemW'(1);
        end
        if (32'(fill_addr_r) == Last) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_accept) begin
          // fetch C(n,i) for the range check
          rank_nxt  = in_tdata[RankW-1:0];
          prev_nxt  = '0;
          sum_nxt   = '0;
          rd_en     = !size_bad;
          state_nxt = S_CHECK;
        end
      end

      S_CHECK: begin
        if (size_bad || (rank_r == '0) || (rank_r > rd_data)) begin
          if (out_free) begin
            out_valid_nxt = 1'b1;
            out_elem_nxt  = '0;
            out_last_nxt  = 1'b1;
            out_err_nxt   = 1'b1;
            state_nxt     = S_IDLE;
          end
        end else if (subset_size_r == ElemW'(1)) begin
          state_nxt = S_LAST;
        end else begin
          // first position: candidate 1, read C(n-1, i-1)
          cand_nxt      = ElemW'(1);
          bsel_nxt      = subset_size_r - ElemW'(1);
          coef_zero_nxt = 1'b0;
          rd_en         = 1'b1;
          rd_addr       = addr_of(set_size_r - ElemW'(1), subset_size_r - ElemW'(1));
          state_nxt     = S_EVAL;
        end
      end

      S_EVAL: begin
        if (keep_going) begin
          // advance the candidate, keep the coefficient in the sum
          sum_nxt       = sum_ext[CoefW-1:0];
          cand_nxt      = cand_r + ElemW'(1);
          coef_zero_nxt = 1'b0;
          rd_en         = 1'b1;
          rd_addr       = addr_of(next_a, bsel_r);
        end else if (out_free) begin
          // drop the last coefficient, emit this candidate
          out_valid_nxt = 1'b1;
          out_elem_nxt  = cand_r;
          out_last_nxt  = 1'b0;
          out_err_nxt   = 1'b0;
          prev_nxt      = cand_r;
          bsel_nxt      = bsel_dec;
          if (bsel_dec == '0) begin
            state_nxt = S_LAST;
          end else begin
            cand_nxt      = cand_r + ElemW'(1);
            coef_zero_nxt = (cand_r >= set_size_r);
            rd_en         = (cand_r < set_size_r);
            rd_addr       = addr_of(next_a, bsel_dec);
          end
        end
      end

      S_LAST: begin
        if (out_free) begin
          out_valid_nxt = 1'b1;
          out_elem_nxt  = prev_r + rank_r[ElemW-1:0] - sum_r[ElemW-1:0];
          out_last_nxt  = 1'b1;
          out_err_nxt   = 1'b0;
          state_nxt     = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // ------------------------------------------------------------------
  // State update
  // ------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_FILL;
      set_size_r    <= SET_SIZE_RST;
      subset_size_r <= SUBSET_SIZE_RST;
      fill_addr_r   <= '0;
      fill_row_r    <= '0;
      fill_col_r    <= '0;
      wr_en_r       <= 1'b0;
      out_valid_r   <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      fill_addr_r <= fill_addr_nxt;
      fill_row_r  <= fill_row_nxt;
      fill_col_r  <= fill_col_nxt;
      wr_en_r     <= wr_en_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          CFG_SET_SIZE:    set_size_r    <= cfg_wdata;
          CFG_SUBSET_SIZE: subset_size_r <= cfg_wdata;
          default: ;
        endcase
      end
    end
  end

  // payload, no reset
  always_ff @(posedge clk) begin
    rank_r      <= rank_nxt;
    cand_r      <= cand_nxt;
    prev_r      <= prev_nxt;
    sum_r       <= sum_nxt;
    bsel_r      <= bsel_nxt;
    coef_zero_r <= coef_zero_nxt;
    wr_addr_r   <= wr_addr_nxt;
    wr_row0_r   <= wr_row0_nxt;
    wr_col0_r   <= wr_col0_nxt;
    prev_rd_r   <= rd_data;
    out_elem_r  <= out_elem_nxt;
    out_last_r  <= out_last_nxt;
    out_err_r   <= out_err_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_elem_r};
  assign out_tlast  = out_last_r;
  assign out_tuser  = out_err_r;

endmodule

// ===== verif/combination_unrank_lex_tb.sv =====
// Self-checking testbench for combination_unrank_lex.
// Drives ranks over the input stream, predicts every element from its own binomial table,
// checks the result stream. Depends on clu_pkg and the combination_unrank_lex RTL.
`timescale 1ns / 1ps

module combination_unrank_lex_tb;
  import clu_pkg::*;

  localparam int MAX_N = 32;
  // Spare register indexes: the block must ignore writes to these
  localparam logic [CfgIdxW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_SPARE_HI = 2'd3;
  localparam int RANDOM_RANKS = 180;
  localparam int SETTLE_CYCLES = 40;
  localparam int LONG_HOLD = 300;
  localparam logic [RankW-1:0] RANK_ALL_ONES = {RankW{1'b1}};

  // One expected result transaction
  typedef struct packed {
    logic [ElemW-1:0] element;
    logic             last;
    logic             rank_error;
  } combo_elem_t;

  // Receiver stall patterns
  typedef enum logic [1:0] {
    RX_OPEN,    // always ready
    RX_SPARSE,  // ready with probability three in four, at random
    RX_COMB,    // fixed stall whenever rx_beat mod 4 is 3
    RX_COIN     // ready half the time
  } rx_mode_t;

  logic               clk;
  logic               rst_n = 1'b0;
  logic               in_tvalid = 1'b0;
  logic               in_tready;
  logic [31:0]        in_tdata = '0;
  logic               out_tvalid;
  logic               out_tready = 1'b0;
  logic [7:0]         out_tdata;
  logic               out_tlast;
  logic               out_tuser;
  logic               cfg_we = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [ElemW-1:0]   cfg_wdata = '0;

  combination_unrank_lex #(.MAX_N(MAX_N)) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .out_tuser  (out_tuser),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  // Predictor state: own copy of the sizes and an exact Pascal table
  int unsigned      pascal [0:MAX_N][0:MAX_N];
  logic [ElemW-1:0] set_size_cur = SET_SIZE_RST;
  logic [ElemW-1:0] subset_size_cur = SUBSET_SIZE_RST;

  logic [RankW-1:0] rank_feed [$];     // ranks not yet offered
  combo_elem_t      elements_due [$];  // predicted elements, oldest first

  int ranks_queued = 0;   // written by the stimulus process only
  int ranks_taken = 0;    // written by the driver only
  int elements_seen = 0;
  int mismatches = 0;
  int settings_used = 0;

  // Sender burst shaping
  int burst_left = 1;
  int gap_left = 0;

  // Receiver pattern and long hold-off
  rx_mode_t rx_mode = RX_OPEN;
  int       rx_mode_left = 0;
  int       rx_beat = 0;
  int       hold_kick = 0;
  int       hold_seen = 0;
  int       hold_left = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Watchdog: generous bound over the slowest legal run
  initial begin
    #4ms;
    $display("Verification failed");
    $finish;
  end

  // C(a,b), zero outside the table
  function automatic int unsigned binom(input int unsigned a, input int unsigned b);
    if (a > MAX_N || b > MAX_N) return 0;
    return pascal[a][b];
  endfunction

  task automatic push_elem(input int unsigned e, input logic l, input logic err);
    combo_elem_t item;
    item.element = e[ElemW-1:0];
    item.last = l;
    item.rank_error = err;
    elements_due.push_back(item);
  endtask

  // Expand one accepted rank into the ascending elements of its combination
  task automatic unrank_rank(input logic [RankW-1:0] rank);
    int unsigned n, i, cand, r, sum, prev, pos, rk;
    n = set_size_cur;
    i = subset_size_cur;
    rk = rank;
    // bad sizes or a rank outside 1..C(n,i): single flagged transaction
    if (n == 0 || n > MAX_N || i == 0 || i > n || rk == 0 || rk > binom(n, i)) begin
      push_elem(0, 1'b1, 1'b1);
      return;
    end
    prev = 0;
    sum = 0;
    for (pos = 0; pos + 1 < i; pos++) begin
      cand = prev;
      r = 0;
      // advance the candidate, summing the combinations that start below it
      do begin
        cand++;
        r = binom(n - cand, i - pos - 1);
        sum += r;
      end while (sum < rk && cand < n);
      sum -= r;  // take back the block that holds the rank
      prev = cand;
      push_elem(cand, 1'b0, 1'b0);
    end
    // final element falls straight out of the remaining offset
    prev = prev + rk - sum;
    push_elem(prev, 1'b1, 1'b0);
  endtask

  task automatic report_mismatch(input string msg);
    mismatches++;
    if (mismatches <= 10) $display("MISMATCH %0d: %s", mismatches, msg);
  endtask

  // Driver: predict on every accepted transaction, then refill the slot
  always @(posedge clk) begin
    if (!rst_n) begin
      in_tvalid <= 1'b0;
      in_tdata <= '0;
    end else begin
      if (in_tvalid && in_tready) begin
        unrank_rank(in_tdata[RankW-1:0]);
        ranks_taken++;
      end
      // hold the current transaction until the block takes it
      if (!in_tvalid || in_tready) begin
        if (gap_left > 0) begin
          gap_left--;
          in_tvalid <= 1'b0;
        end else if (rank_feed.size() > 0) begin
          in_tvalid <= 1'b1;
          in_tdata <= {2'b00, rank_feed.pop_front()};
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            // new burst; a third of them follow on with no gap at all
            burst_left = $urandom_range(12, 1);
            gap_left = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(6, 1);
          end
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // Long receiver hold-off, counted here so the stimulus never waits on it
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_left <= 0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
    end else if (hold_kick != hold_seen) begin
      hold_left <= LONG_HOLD;
      hold_seen <= hold_kick;
    end
  end

  // Monitor: check each result transaction against the oldest prediction
  always @(posedge clk) begin
    combo_elem_t due;
    logic        rdy;
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) begin
        elements_seen++;
        if (elements_due.size() == 0) begin
          report_mismatch($sformatf("unexpected result tdata %0h last %0b err %0b",
                                    out_tdata, out_tlast, out_tuser));
        end else begin
          due = elements_due.pop_front();
          if (out_tdata !== {2'b00, due.element} || out_tlast !== due.last ||
              out_tuser !== due.rank_error) begin
            report_mismatch($sformatf(
              "expected element %0d last %0b err %0b, got tdata %0h last %0b err %0b",
              due.element, due.last, due.rank_error, out_tdata, out_tlast, out_tuser));
          end
        end
      end
      // switch to a new random stall pattern when the current one runs out
      if (rx_mode_left == 0) begin
        rx_mode = rx_mode_t'($urandom_range(3, 0));
        rx_mode_left = $urandom_range(80, 20);
      end else begin
        rx_mode_left--;
      end
      rx_beat++;
      case (rx_mode)
        RX_OPEN:   rdy = 1'b1;
        RX_SPARSE: rdy = ($urandom_range(3, 0) != 0);
        RX_COMB:   rdy = (rx_beat % 4 != 3);
        default:   rdy = ($urandom_range(1, 0) == 1);
      endcase
      out_tready <= rdy && (hold_left == 0);
    end
  end

  // One register write; update the predictor's copy alongside
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [ElemW-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_SET_SIZE) set_size_cur = val;
    else if (idx == CFG_SUBSET_SIZE) subset_size_cur = val;
  endtask

  task automatic set_sizes(input logic [ElemW-1:0] n, input logic [ElemW-1:0] i);
    write_reg(CFG_SET_SIZE, n);
    write_reg(CFG_SUBSET_SIZE, i);
    settings_used++;
  endtask

  task automatic send(input logic [RankW-1:0] rank);
    rank_feed.push_back(rank);
    ranks_queued++;
  endtask

  // Wait until every rank is taken and every element has come, then let the walk settle
  task automatic drain();
    while (ranks_taken != ranks_queued || elements_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    int unsigned a, b, n, i, c, cnt, k;
    int          phase, random_sent;
    logic [RankW-1:0] rk;

    // Build the expected binomial table by Pascal's rule
    for (a = 0; a <= MAX_N; a++) begin
      for (b = 0; b <= MAX_N; b++) pascal[a][b] = 0;
      pascal[a][0] = 1;
      for (b = 1; b <= a; b++) pascal[a][b] = pascal[a-1][b-1] + pascal[a-1][b];
    end

    // Hold reset, then release it once
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // --- Directed part ---
    // Reset sizes (n = 32, subset of one): the element is the rank itself
    send(1);
    send(32);
    send(0);               // rank zero
    send(33);              // just over C(32,1)
    send(RANK_ALL_ONES);   // every rank bit set
    drain();

    // Widest table entry C(32,16); spare indexes must not disturb the sizes
    set_sizes(6'd32, 6'd16);
    write_reg(CFG_SPARE_LO, 6'h3F);
    write_reg(CFG_SPARE_HI, 6'h00);
    send(1);
    send(601080390);       // top rank
    send(601080391);       // one past the top
    send(300000000);
    drain();

    // Full subset: only rank 1 is valid
    set_sizes(6'd32, 6'd32);
    send(1);
    send(2);
    drain();

    set_sizes(6'd5, 6'd3);
    send(1);
    send(10);
    send(11);
    send(5);
    drain();

    // Bad sizes: all give one flagged transaction
    set_sizes(6'd0, 6'd0);
    send(1);
    drain();
    set_sizes(6'd40, 6'd1);
    send(1);
    drain();
    set_sizes(6'h3F, 6'h3F);
    send(1);
    drain();
    set_sizes(6'd4, 6'd5);   // subset larger than set
    send(1);
    drain();
    set_sizes(6'd4, 6'd0);
    send(1);
    drain();

    set_sizes(6'd1, 6'd1);
    send(1);
    drain();

    // --- Random part: mostly valid ranks for the current sizes ---
    phase = 0;
    random_sent = 0;
    while (random_sent < RANDOM_RANKS) begin
      phase++;
      case ($urandom_range(9, 0))
        0: begin
          // bad sizes of every kind
          case ($urandom_range(3, 0))
            0: begin n = 0; i = $urandom_range(63, 0); end
            1: begin n = $urandom_range(63, MAX_N + 1); i = $urandom_range(63, 0); end
            2: begin n = $urandom_range(MAX_N, 1); i = 0; end
            default: begin n = $urandom_range(MAX_N - 1, 1); i = $urandom_range(63, n + 1); end
          endcase
        end
        1, 2: begin
          n = MAX_N;
          i = $urandom_range(MAX_N, 1);
        end
        default: begin
          n = $urandom_range(12, 1);
          case ($urandom_range(3, 0))
            0: i = 1;
            1: i = n;
            default: i = $urandom_range(n, 1);
          endcase
        end
      endcase
      drain();
      set_sizes(n[ElemW-1:0], i[ElemW-1:0]);
      c = (n >= 1 && n <= MAX_N && i >= 1 && i <= n) ? pascal[n][i] : 0;
      // stall the receiver for a long stretch while ranks keep coming
      if (phase == 3 || phase == 9) hold_kick <= hold_kick + 1;
      cnt = $urandom_range(14, 6);
      for (k = 0; k < cnt; k++) begin
        case ($urandom_range(9, 0))
          0: rk = '0;
          1: rk = (c != 0 && c < RANK_ALL_ONES) ? RankW'($urandom_range(RANK_ALL_ONES, c + 1))
                                                : RankW'($urandom());
          2: rk = RankW'($urandom());
          default: rk = (c != 0) ? RankW'($urandom_range(c, 1)) : RankW'($urandom());
        endcase
        send(rk);
        random_sent++;
      end
    end

    drain();
    $display("Summary: %0d ranks over %0d size settings, %0d elements checked, %0d mismatches",
             ranks_taken, settings_used, elements_seen, mismatches);
    if (elements_due.size() != 0)
      report_mismatch($sformatf("%0d expected elements never arrived", elements_due.size()));
    if (mismatches == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/clu_pkg.sv
hdl/clu_ram.sv
hdl/combination_unrank_lex.sv
verif/combination_unrank_lex_tb.sv
